@@ rtl/inb_pkg.sv @@
// Package for the I/Q impulse noise blanker: shared types and constants.
// No dependencies.
`timescale 1ns / 1ps
package inb_pkg;

  // Average filter coefficient, 1049/2^20, and its shift.
  localparam int unsigned AvgCoef  = 1049;
  localparam int unsigned AvgShift = 20;
  localparam logic [32:0] AvgMax   = 33'h0_FFFF_FFFF;

  // Threshold clamp limits, Q5.8 for stage one and Q4.8 for stage two.
  localparam logic [12:0] Thr1Min = 13'd256;
  localparam logic [12:0] Thr1Max = 13'd5120;
  localparam logic [11:0] Thr2Max = 12'd3840;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_FIRST_EN  = 2'd0,
    REG_FIRST_THR = 2'd1,
    REG_SECOND_EN = 2'd2,
    REG_SECOND_THR = 2'd3
  } reg_idx_e;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_S1_SQRT,
    ST_S1_AVG,
    ST_S1_CMP,
    ST_S1_DONE,
    ST_S2_START,
    ST_S2_SQRT,
    ST_S2_AVG,
    ST_S2_CMP,
    ST_S2_DONE,
    ST_OUT
  } state_e;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;       // capture a new sample
    logic sqrt_start; // start magnitude of current working sample
    logic avg_mul;    // first multiply step of average update
    logic avg_upd;    // form new average
    logic cmp_mul;    // threshold product
    logic s1_done;    // stage one decision and ring update
    logic s2_done;    // stage two decision
    logic sel2;       // work on stage two state
    logic out_load;   // move result to output register
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic sqrt_busy;
    logic first_en;
    logic second_en;
  } stat_t;

endpackage

@@ rtl/inb_stream_if.sv @@
// Valid/ready stream interface carrying one I/Q item.
// Depends on nothing; width follows the SAMPLE_BITS parameter.
`timescale 1ns / 1ps
interface inb_stream_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] i;
  logic signed [SAMPLE_BITS-1:0] q;
  logic                          last;
  logic                          zeroed;
  logic                          replaced;

  modport source (output valid, i, q, last, zeroed, replaced, input ready);
  modport sink (input valid, i, q, last, zeroed, replaced, output ready);
endinterface

@@ rtl/inb_ctrl.sv @@
// Controller state machine of the noise blanker.
// Depends on inb_pkg.
`timescale 1ns / 1ps
module inb_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           out_busy_i,
  input  inb_pkg::stat_t stat_i,
  output inb_pkg::cmd_t  cmd_o
);
  import inb_pkg::*;

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_S1_SQRT;
        end
      end
      ST_S1_SQRT: begin
        if (!stat_i.first_en) begin
          state_d = ST_S2_START;
        end else if (!stat_i.sqrt_busy) begin
          state_d = ST_S1_AVG;
        end
      end
      ST_S1_AVG:  state_d = ST_S1_CMP;
      ST_S1_CMP:  state_d = ST_S1_DONE;
      ST_S1_DONE: state_d = ST_S2_START;
      ST_S2_START: begin
        if (!stat_i.second_en) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_S2_SQRT;
        end
      end
      ST_S2_SQRT: begin
        if (!stat_i.sqrt_busy) begin
          state_d = ST_S2_AVG;
        end
      end
      ST_S2_AVG:  state_d = ST_S2_CMP;
      ST_S2_CMP:  state_d = ST_S2_DONE;
      ST_S2_DONE: state_d = ST_OUT;
      ST_OUT: begin
        if (!out_busy_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs. Stage one's square root starts on load; stage two's starts once
  // the stage-one result sits in the working sample.
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o       = 1'b1;
        cmd_o.load       = in_valid_i;
        cmd_o.sqrt_start = in_valid_i;
      end
      ST_S1_AVG: cmd_o.avg_mul = 1'b1;
      ST_S1_CMP: begin
        cmd_o.avg_upd = 1'b1;
        cmd_o.cmp_mul = 1'b1;
      end
      ST_S1_DONE: cmd_o.s1_done = 1'b1;
      ST_S2_START: begin
        cmd_o.sel2       = 1'b1;
        cmd_o.sqrt_start = stat_i.second_en;
      end
      ST_S2_SQRT: cmd_o.sel2 = 1'b1;
      ST_S2_AVG: begin
        cmd_o.sel2    = 1'b1;
        cmd_o.avg_mul = 1'b1;
      end
      ST_S2_CMP: begin
        cmd_o.sel2    = 1'b1;
        cmd_o.avg_upd = 1'b1;
        cmd_o.cmp_mul = 1'b1;
      end
      ST_S2_DONE: begin
        cmd_o.sel2    = 1'b1;
        cmd_o.s2_done = 1'b1;
      end
      ST_OUT: cmd_o.out_load = !out_busy_i;
      default: ;
    endcase
  end
endmodule

@@ rtl/inb_datapath.sv @@
// Datapath of the noise blanker: iterative square root, average filters,
// delay ring, hang counter, smoother and output register. Depends on inb_pkg.
`timescale 1ns / 1ps
module inb_datapath #(
  parameter int RING_DEPTH   = 8,
  parameter int HANG_SAMPLES = 7,
  parameter int SAMPLE_BITS  = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  inb_pkg::cmd_t                 cmd_i,
  output inb_pkg::stat_t                stat_o,
  input  logic                          first_en_i,
  input  logic [12:0]                   first_thr_i,
  input  logic                          second_en_i,
  input  logic [11:0]                   second_thr_i,
  input  logic signed [SAMPLE_BITS-1:0] in_i_i,
  input  logic signed [SAMPLE_BITS-1:0] in_q_i,
  input  logic                          in_last_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] out_i_o,
  output logic signed [SAMPLE_BITS-1:0] out_q_o,
  output logic                          out_last_o,
  output logic                          out_zeroed_o,
  output logic                          out_replaced_o
);
  import inb_pkg::*;

  localparam int SB    = SAMPLE_BITS;
  localparam int SQW   = 2 * SB;            // width of I^2+Q^2
  localparam int MAGW  = SB;                // magnitude width
  localparam int PTRW  = $clog2(RING_DEPTH);
  localparam int SMW   = SB + 2;
  localparam int ITERS = SB;
  localparam int ITW   = $clog2(ITERS + 1);
  // Width of the threshold comparison: mag<<24 against a 13 x 32 bit product.
  localparam int CMPW  = (MAGW + 24 > 45) ? MAGW + 24 : 45;
  localparam logic [63:0] AvgOneFull = 64'd1 << (SB + 15);
  localparam logic [31:0] AvgOne =
    (AvgOneFull > 64'(AvgMax)) ? 32'hFFFF_FFFF : AvgOneFull[31:0];
  localparam logic [PTRW-1:0] PtrStep = PTRW'(1);
  localparam logic [PTRW-1:0] RdReset = PTRW'(2 % RING_DEPTH);
  localparam logic [2:0] HangLoad = 3'(HANG_SAMPLES);

  // Working sample and flags.
  logic signed [SB-1:0] wi_q, wq_q;
  logic                 last_q, zeroed_q, replaced_q;

  // Ring, pointers, hang counter, averages, smoother state.
  logic signed [SB-1:0] ring_i_q [RING_DEPTH];
  logic signed [SB-1:0] ring_q_q [RING_DEPTH];
  logic [PTRW-1:0]      wp_q, rp_q;
  logic [2:0]           hang_q;
  logic [31:0]          avg1_q, avg2_q;
  logic signed [SMW-1:0] smi_q, smq_q;

  // Square root unit: one result bit per cycle.
  logic [MAGW-1:0] root_q;
  logic [ITW-1:0]  it_q;
  logic            sq_busy_q;
  logic [SQW-1:0]  sq_src;
  logic signed [SB-1:0] src_i, src_q;
  logic [SQW-1:0]  rad_q;
  logic [MAGW+1:0] part_q;
  logic [MAGW+1:0] part_sh;
  logic [MAGW+1:0] cand;

  // Arithmetic registers.
  logic [42:0] prod_a_q;  // avg * coef
  logic [52:0] prod_m_q;  // (mag<<16) * coef
  logic [CMPW-1:0] thr_prod_q;
  logic [31:0] avg_sel, avg_new;
  logic [33:0] avg_sum;
  logic [12:0] thr_sel;
  logic [12:0] thr1_c;
  logic [11:0] thr2_c;
  logic [CMPW-1:0] mag_sh;
  logic        over;

  // Smoother combinational values.
  logic signed [SMW+1:0] smi3, smq3;
  logic signed [SMW-1:0] smi_n, smq_n;

  // Ring read of the current tap.
  logic signed [SB-1:0] ring_rd_i, ring_rd_q;

  // Output register.
  logic                 ov_q;
  logic signed [SB-1:0] oi_q, oq_q;
  logic                 ol_q, oz_q, orp_q;

  // Selected square root source: working sample, or the new input on load.
  assign src_i  = cmd_i.load ? in_i_i : wi_q;
  assign src_q  = cmd_i.load ? in_q_i : wq_q;
  assign sq_src = SQW'(src_i * src_i) + SQW'(src_q * src_q);

  // Square root: digit-by-digit on the radicand shifted out of rad_q top.
  assign part_sh = {part_q[MAGW-1:0], rad_q[SQW-1 -: 2]};
  assign cand    = {root_q, 2'b01};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_busy_q <= 1'b0;
      it_q      <= '0;
    end else if (cmd_i.sqrt_start) begin
      sq_busy_q <= 1'b1;
      it_q      <= ITW'(ITERS);
    end else if (sq_busy_q) begin
      it_q <= it_q - ITW'(1);
      if (it_q == ITW'(1)) begin
        sq_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_start) begin
      rad_q  <= sq_src;
      part_q <= '0;
      root_q <= '0;
    end else if (sq_busy_q) begin
      rad_q <= {rad_q[SQW-3:0], 2'b00};
      if (part_sh >= cand) begin
        part_q <= part_sh - cand;
        root_q <= {root_q[MAGW-2:0], 1'b1};
      end else begin
        part_q <= part_sh;
        root_q <= {root_q[MAGW-2:0], 1'b0};
      end
    end
  end

  assign stat_o.sqrt_busy = sq_busy_q | cmd_i.sqrt_start;
  assign stat_o.first_en  = first_en_i;
  assign stat_o.second_en = second_en_i;

  // Threshold clamps.
  assign thr1_c = (first_thr_i < Thr1Min) ? Thr1Min :
                  (first_thr_i > Thr1Max) ? Thr1Max : first_thr_i;
  assign thr2_c = (second_thr_i > Thr2Max) ? Thr2Max : second_thr_i;
  assign thr_sel = cmd_i.sel2 ? {1'b0, thr2_c} : thr1_c;
  assign avg_sel = cmd_i.sel2 ? avg2_q : avg1_q;

  // Average update: two products, then subtract/add and saturate.
  assign avg_sum = {2'b00, avg_sel} - 34'(prod_a_q >> AvgShift)
                 + 34'(prod_m_q >> AvgShift);
  assign avg_new = (avg_sum > {1'b0, AvgMax}) ? 32'hFFFF_FFFF : avg_sum[31:0];
  assign mag_sh  = CMPW'(root_q) << 24;
  assign over    = mag_sh > thr_prod_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.avg_mul) begin
      prod_a_q <= 43'(avg_sel) * 43'(AvgCoef);
      prod_m_q <= 53'({root_q, 16'h0000}) * 53'(AvgCoef);
    end
    if (cmd_i.cmp_mul) begin
      thr_prod_q <= CMPW'(thr_sel) * CMPW'(avg_new);
    end
  end

  // Smoother: s' = floor(3s/4) + x.
  assign smi3  = (SMW+2)'(3 * (SMW+2)'(smi_q));
  assign smq3  = (SMW+2)'(3 * (SMW+2)'(smq_q));
  assign smi_n = SMW'(smi3 >>> 2) + SMW'(wi_q);
  assign smq_n = SMW'(smq3 >>> 2) + SMW'(wq_q);

  assign ring_rd_i = ring_i_q[rp_q];
  assign ring_rd_q = ring_q_q[rp_q];

  // Control state of the stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      rp_q   <= RdReset;
      hang_q <= '0;
      avg1_q <= AvgOne;
      avg2_q <= AvgOne;
      smi_q  <= '0;
      smq_q  <= '0;
      for (int k = 0; k < RING_DEPTH; k++) begin
        ring_i_q[k] <= '0;
        ring_q_q[k] <= '0;
      end
    end else begin
      if (cmd_i.avg_upd && !cmd_i.sel2) begin
        avg1_q <= avg_new;
      end
      if (cmd_i.avg_upd && cmd_i.sel2) begin
        avg2_q <= avg_new;
        smi_q  <= smi_n;
        smq_q  <= smq_n;
      end
      if (cmd_i.s1_done) begin
        ring_i_q[wp_q] <= wi_q;
        ring_q_q[wp_q] <= wq_q;
        wp_q <= (wp_q == '0) ? PTRW'(RING_DEPTH - 1) : wp_q - PtrStep;
        rp_q <= (rp_q == '0) ? PTRW'(RING_DEPTH - 1) : rp_q - PtrStep;
        if (hang_q != '0) begin
          hang_q <= hang_q - 3'd1;
        end else if (over) begin
          hang_q <= HangLoad - 3'd1;
        end
      end
    end
  end

  // Working sample.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      wi_q       <= in_i_i;
      wq_q       <= in_q_i;
      last_q     <= in_last_i;
      zeroed_q   <= 1'b0;
      replaced_q <= 1'b0;
    end else if (cmd_i.s1_done) begin
      if (hang_q != '0 || over) begin
        wi_q     <= '0;
        wq_q     <= '0;
        zeroed_q <= 1'b1;
      end else if (rp_q == wp_q) begin
        wi_q <= wi_q;
        wq_q <= wq_q;
      end else begin
        wi_q <= ring_rd_i;
        wq_q <= ring_rd_q;
      end
    end else if (cmd_i.s2_done && over) begin
      wi_q       <= SB'(smi_q >>> 2);
      wq_q       <= SB'(smq_q >>> 2);
      replaced_q <= 1'b1;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      ov_q <= 1'b1;
    end else if (out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      oi_q  <= wi_q;
      oq_q  <= wq_q;
      ol_q  <= last_q;
      oz_q  <= zeroed_q;
      orp_q <= replaced_q;
    end
  end

  assign out_valid_o    = ov_q;
  assign out_i_o        = oi_q;
  assign out_q_o        = oq_q;
  assign out_last_o     = ol_q;
  assign out_zeroed_o   = oz_q;
  assign out_replaced_o = orp_q;
endmodule

@@ rtl/iq_impulse_noise_blanker_unit.sv @@
// Top level of the I/Q impulse noise blanker: APB registers, controller and
// datapath. Depends on inb_pkg, inb_stream_if, inb_ctrl and inb_datapath.
`timescale 1ns / 1ps
// One sample is handled at a time. An enabled stage one or stage two adds the
// bit-serial square root plus the average and threshold steps to a request's
// time in the block. The result appears in the same cycle as the next request
// can be taken. The output register lets the next request be taken and worked
// on while the last result is unread; the block then waits until the output
// register is free.
module iq_impulse_noise_blanker_unit #(
  parameter int RING_DEPTH   = 8,
  parameter int HANG_SAMPLES = 7,
  parameter int SAMPLE_BITS  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  inb_stream_if.sink  in_if,
  inb_stream_if.source out_if
);
  import inb_pkg::*;

  logic        fen_q, sen_q;
  logic [12:0] fthr_q;
  logic [11:0] sthr_q;
  cmd_t        cmd;
  stat_t       stat;
  reg_idx_e    idx;
  logic        wr;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr     = psel && penable && pwrite;

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fen_q  <= 1'b0;
      fthr_q <= 13'd2560;
      sen_q  <= 1'b0;
      sthr_q <= 12'd1280;
    end else if (wr) begin
      unique case (idx)
        REG_FIRST_EN:   fen_q  <= pwdata[0];
        REG_FIRST_THR:  fthr_q <= pwdata[12:0];
        REG_SECOND_EN:  sen_q  <= pwdata[0];
        REG_SECOND_THR: sthr_q <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    unique case (idx)
      REG_FIRST_EN:   prdata = {31'd0, fen_q};
      REG_FIRST_THR:  prdata = {19'd0, fthr_q};
      REG_SECOND_EN:  prdata = {31'd0, sen_q};
      REG_SECOND_THR: prdata = {20'd0, sthr_q};
      default:        prdata = '0;
    endcase
  end

  inb_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .out_busy_i (out_if.valid && !out_if.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  inb_datapath #(
    .RING_DEPTH  (RING_DEPTH),
    .HANG_SAMPLES(HANG_SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i         (cmd),
    .stat_o        (stat),
    .first_en_i    (fen_q),
    .first_thr_i   (fthr_q),
    .second_en_i   (sen_q),
    .second_thr_i  (sthr_q),
    .in_i_i        (in_if.i),
    .in_q_i        (in_if.q),
    .in_last_i     (in_if.last),
    .out_valid_o   (out_if.valid),
    .out_ready_i   (out_if.ready),
    .out_i_o       (out_if.i),
    .out_q_o       (out_if.q),
    .out_last_o    (out_if.last),
    .out_zeroed_o  (out_if.zeroed),
    .out_replaced_o(out_if.replaced)
  );
endmodule

@@ rtl/inb_checker.sv @@
// Port-level checker for the noise blanker, bound to the top level.
// Depends on the top level's port list.
`timescale 1ns / 1ps
module inb_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);
  // A result stays offered until taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");

  // A request is never accepted in the cycle right after another.
  a_no_b2b: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready) else $error("back to back accept");

  // No result appears in the cycle after a request is accepted.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && !out_valid |=> !out_valid) else $error("early result");
endmodule

bind iq_impulse_noise_blanker_unit inb_checker u_chk (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .in_valid (in_if.valid),
  .in_ready (in_if.ready),
  .out_valid(out_if.valid),
  .out_ready(out_if.ready)
);
